// File: rtl/core/tgs_pkg.sv
// shared types, command codes and sine table builder for the turtle geometry block
`default_nettype none

package tgs_pkg;

  // command codes carried in the func field
  typedef enum logic [2:0] {
    CMD_FORWARD = 3'd0,
    CMD_ROTATE  = 3'd1,
    CMD_PUSH    = 3'd2,
    CMD_POP     = 3'd3,
    CMD_JUMP    = 3'd4,
    CMD_SET_HD  = 3'd5,
    CMD_NARROW  = 3'd6
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_STEP_LENGTH   = 2'd0,
    CFG_NARROW_FACTOR = 2'd1,
    CFG_INITIAL_WIDTH = 2'd2
  } cfg_idx_e;

  localparam logic [9:0]  StepLengthRst   = 10'd10;
  localparam logic [15:0] NarrowFactorRst = 16'd49152;
  localparam logic [15:0] InitialWidthRst = 16'd1024;
  localparam logic [63:0] HalfPiQ30       = 64'd1686629713;

  // input beat
  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        turn_angle;
    logic               keep_width;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic               line_valid;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [15:0]        line_width;
    logic               stack_overflow;
  } out_beat_t;

  // one saved turtle state
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] hd;
  } stack_ent_t;

  // sin(pi/2 * k / 2^qbits) in q1.15, taylor series in q30, only evaluated at elaboration
  function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned qbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x    = (HalfPiQ30 * 64'(k)) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r[14:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tgs_sin_rom.sv
// quarter-wave sine rom with registered sine and cosine reads for one heading
`default_nettype none

module tgs_sin_rom
  import tgs_pkg::*;
#(
  parameter int TAB_BITS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rd_en_i,
  input  wire logic [15:0]        heading_i,
  output logic signed [15:0]      sin_o,
  output logic signed [15:0]      cos_o
);

  localparam int QBITS   = TAB_BITS - 2;
  localparam int QUARTER = 1 << QBITS;

  // quarter table, entries 0 to a full quarter inclusive
  logic [14:0] qtab [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
    assign qtab[g] = quarter_sine(g, QBITS);
  end

  // fold full-turn index into quarter address and sign
  logic [TAB_BITS-1:0] idx;
  logic [1:0]          quad_s;
  logic [1:0]          quad_c;
  logic [QBITS-1:0]    rem;
  logic [QBITS:0]      addr_s;
  logic [QBITS:0]      addr_c;
  logic [15:0]         mag_s;
  logic [15:0]         mag_c;

  always_comb begin
    idx    = heading_i[15 -: TAB_BITS];
    quad_s = idx[TAB_BITS-1 -: 2];
    quad_c = quad_s + 2'd1;
    rem    = idx[QBITS-1:0];
    addr_s = quad_s[0] ? ((QBITS+1)'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
    addr_c = quad_c[0] ? ((QBITS+1)'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
    mag_s  = {1'b0, qtab[addr_s]};
    mag_c  = {1'b0, qtab[addr_c]};
  end

  // registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sin_o <= quad_s[1] ? $signed(16'd0 - mag_s) : $signed(mag_s);
      cos_o <= quad_c[1] ? $signed(16'd0 - mag_c) : $signed(mag_c);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/turtle_geometry_with_stack.sv
// turtle geometry engine: position, heading, width and a save stack in memory
// an accepted command waits in the work stage, its result beat in the output register
// one command per cycle unless stalled; stack and sine reads are issued at accept from
// the next-state values, with a bypass when a push and the following pop hit one entry
// reset: position, heading and stack depth clear, width and registers take their
// reset values; stack memory is not cleared, entries above the depth are never popped
`default_nettype none

module turtle_geometry_with_stack
  import tgs_pkg::*;
#(
  parameter int STACK_DEPTH     = 64,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_beat_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_beat_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // configuration
  logic [9:0]  step_q;
  logic [15:0] nfac_q;

  // turtle state
  logic [15:0]   x_q, x_d;
  logic [15:0]   y_q, y_d;
  logic [15:0]   hd_q, hd_d;
  logic [15:0]   width_q, width_d;
  logic [DW-1:0] depth_q, depth_d;

  // work stage and output register
  logic        s_valid_q;
  in_beat_t    s_cmd_q;
  logic        out_valid_q;
  out_beat_t   out_q;
  logic        s_fire;
  logic        in_acc;

  // stack memory and bypass
  stack_ent_t  stack_mem [STACK_DEPTH];
  stack_ent_t  pop_rd_q;
  stack_ent_t  fwd_ent_q;
  logic        fwd_q;
  stack_ent_t  push_ent;
  stack_ent_t  pop_ent;
  logic        push_we;
  logic [DW-1:0] rd_dec;
  logic [AW-1:0] rd_addr;

  // sine rom
  logic signed [15:0] sin_w;
  logic signed [15:0] cos_w;

  // exec datapath
  logic signed [26:0] mul_c, mul_s, adj_c, adj_s;
  logic [15:0]        dx, dy;
  logic [31:0]        wprod;
  logic               ovf;
  logic               lv;

  // handshake
  assign s_fire      = s_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s_valid_q && !s_fire;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // forward step products, truncated toward zero, and the narrowing product
  always_comb begin
    mul_c = 27'($signed({1'b0, step_q})) * 27'(cos_w);
    mul_s = 27'($signed({1'b0, step_q})) * 27'(sin_w);
    adj_c = mul_c + (mul_c[26] ? 27'sd32767 : 27'sd0);
    adj_s = mul_s + (mul_s[26] ? 27'sd32767 : 27'sd0);
    dx    = {{4{adj_c[26]}}, adj_c[26:15]};
    dy    = {{4{adj_s[26]}}, adj_s[26:15]};
    wprod = 32'(width_q) * 32'(nfac_q);
  end

  assign push_ent = '{x: x_q, y: y_q, hd: hd_q};
  assign pop_ent  = fwd_q ? fwd_ent_q : pop_rd_q;

  // command execution
  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    hd_d    = hd_q;
    width_d = width_q;
    depth_d = depth_q;
    push_we = 1'b0;
    ovf     = 1'b0;
    lv      = 1'b0;
    if (s_fire) begin
      unique case (s_cmd_q.func)
        CMD_FORWARD: begin
          x_d = x_q + dx;
          y_d = y_q + dy;
          lv  = 1'b1;
        end
        CMD_ROTATE: hd_d = hd_q + s_cmd_q.turn_angle;
        CMD_PUSH: begin
          if (depth_q < DW'(STACK_DEPTH)) begin
            push_we = 1'b1;
            depth_d = depth_q + DW'(1);
          end else begin
            ovf = 1'b1;
          end
        end
        CMD_POP: begin
          if (depth_q != '0) begin
            depth_d = depth_q - DW'(1);
            x_d     = pop_ent.x;
            y_d     = pop_ent.y;
            hd_d    = pop_ent.hd;
          end
        end
        CMD_JUMP: begin
          x_d = s_cmd_q.pos_x;
          y_d = s_cmd_q.pos_y;
        end
        CMD_SET_HD: hd_d = s_cmd_q.turn_angle;
        CMD_NARROW: begin
          if (!s_cmd_q.keep_width) begin
            width_d = wprod[31:16];
          end
        end
        default: ;
      endcase
    end
    if (cfg_we_i && cfg_idx_i == CFG_INITIAL_WIDTH) begin
      width_d = cfg_data_i;
    end
  end

  // pop read address from the next depth
  always_comb begin
    rd_dec  = depth_d - DW'(1);
    rd_addr = rd_dec[AW-1:0];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepLengthRst;
      nfac_q <= NarrowFactorRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_LENGTH:   step_q <= cfg_data_i[9:0];
        CFG_NARROW_FACTOR: nfac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // turtle state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      hd_q        <= '0;
      width_q     <= InitialWidthRst;
      depth_q     <= '0;
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      x_q     <= x_d;
      y_q     <= y_d;
      hd_q    <= hd_d;
      width_q <= width_d;
      depth_q <= depth_d;
      if (in_acc) begin
        s_valid_q <= 1'b1;
        fwd_q     <= push_we;
      end else if (s_fire) begin
        s_valid_q <= 1'b0;
      end
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // work stage and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_cmd_q   <= in_data_i;
      fwd_ent_q <= push_ent;
    end
    if (s_fire) begin
      out_q.line_valid     <= lv;
      out_q.start_x        <= x_q;
      out_q.start_y        <= y_q;
      out_q.end_x          <= x_d;
      out_q.end_y          <= y_d;
      out_q.line_width     <= width_d;
      out_q.stack_overflow <= ovf;
    end
  end

  // save stack memory
  always_ff @(posedge clk_i) begin
    if (push_we) begin
      stack_mem[depth_q[AW-1:0]] <= push_ent;
    end
    if (in_acc) begin
      pop_rd_q <= stack_mem[rd_addr];
    end
  end

  // sine and cosine for the heading the next command will see
  tgs_sin_rom #(
    .TAB_BITS (SINE_TABLE_BITS)
  ) u_sin_rom (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .heading_i (hd_d),
    .sin_o     (sin_w),
    .cos_o     (cos_w)
  );

endmodule

`default_nettype wire

// File: rtl/core/tgs_checker.sv
// port-level checks for the turtle geometry block and their bind
`default_nettype none

module tgs_checker
  import tgs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_beat_t out_data_o
);

  logic        in_acc;
  logic        out_acc;
  logic        seen_q;
  logic [15:0] last_x_q;
  logic [15:0] last_y_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // end point of the last delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else if (out_acc) begin
      seen_q   <= 1'b1;
      last_x_q <= out_data_o.end_x;
      last_y_q <= out_data_o.end_y;
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // once an accepted command has passed the work stage and the output register, a beat is valid on the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##2 out_valid_o)
    else $error("no result after accepted command");

  // each segment starts where the previous beat ended
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> out_data_o.start_x == last_x_q && out_data_o.start_y == last_y_q)
    else $error("start point does not follow previous end point");

  // a dropped push draws nothing and does not move
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stack_overflow |->
      !out_data_o.line_valid && out_data_o.start_x == out_data_o.end_x &&
      out_data_o.start_y == out_data_o.end_y)
    else $error("overflow beat moved the turtle");

endmodule

bind turtle_geometry_with_stack tgs_checker u_tgs_checker (.*);

`default_nettype wire

// File: verif/tb.sv
// self-checking testbench for the turtle geometry block with its save stack
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgs_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int SINE_BITS   = 10;
  localparam int LUT_SIZE    = 1 << SINE_BITS;
  localparam int LUT_QTR     = LUT_SIZE / 4;
  localparam int PHASE_BEATS = 190;
  localparam int MAX_REPORTS = 10;

  // code seven is not a command, the block must leave its state alone
  localparam logic [2:0] CmdUnused = 3'd7;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  // one row of the directed table
  typedef struct {
    row_kind_e   kind;
    in_beat_t    beat;
    bit          fixed;
    out_beat_t   want;
    cfg_idx_e    reg_idx;
    logic [15:0] reg_val;
  } drow_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  // predicted turtle state and register copies
  logic [15:0] tur_x, tur_y, tur_hd, tur_width;
  stack_ent_t  save_stack [STACK_DEPTH];
  int          save_depth;
  logic [9:0]  len_cfg;
  logic [15:0] narrow_cfg;
  int          sine_lut [LUT_SIZE];

  out_beat_t   seg_expect_q [$];
  drow_t       dir_rows [$];

  int snd_idle, rcv_idle;
  int beats_sent, beats_checked, errors;
  int lines_drawn, push_drops, empty_pops;

  turtle_geometry_with_stack #(
    .STACK_DEPTH    (STACK_DEPTH),
    .SINE_TABLE_BITS(SINE_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // sin over a quarter turn in q1.15, series evaluated in q30
  function automatic int quarter_wave(int unsigned k);
    longint unsigned ang, ang_sq, term;
    longint          acc, rnd;
    ang    = (64'(HalfPiQ30) * 64'(k)) / 64'(LUT_QTR);
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = longint'(ang);
    for (int n = 1; n <= 6; n++) begin
      term = (term * ang_sq) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rnd = (acc + 16384) >>> 15;
    if (rnd > 32767) begin
      rnd = 32767;
    end
    return int'(rnd);
  endfunction

  // full-turn table from mirrored quarter waves
  function automatic void build_sine_lut();
    int quad, rem, v;
    for (int i = 0; i < LUT_SIZE; i++) begin
      quad = i / LUT_QTR;
      rem  = i % LUT_QTR;
      v = (quad % 2 == 1) ? quarter_wave(LUT_QTR - rem) : quarter_wave(rem);
      sine_lut[i] = (quad >= 2) ? -v : v;
    end
  endfunction

  // next turtle state and the segment beat one command gives
  function automatic out_beat_t turtle_predict(in_beat_t b);
    out_beat_t   r;
    int          lut_i, sn, cs, dx, dy;
    logic [31:0] wprod;
    r = '0;
    r.start_x = tur_x;
    r.start_y = tur_y;
    case (b.func)
      CMD_FORWARD: begin
        lut_i = int'(tur_hd >> (16 - SINE_BITS));
        sn    = sine_lut[lut_i];
        cs    = sine_lut[(lut_i + LUT_QTR) % LUT_SIZE];
        dx    = (int'(len_cfg) * cs) / 32768;
        dy    = (int'(len_cfg) * sn) / 32768;
        tur_x = tur_x + dx[15:0];
        tur_y = tur_y + dy[15:0];
        r.line_valid = 1'b1;
        lines_drawn++;
      end
      CMD_ROTATE: tur_hd = tur_hd + b.turn_angle;
      CMD_PUSH: begin
        if (save_depth < STACK_DEPTH) begin
          save_stack[save_depth].x  = tur_x;
          save_stack[save_depth].y  = tur_y;
          save_stack[save_depth].hd = tur_hd;
          save_depth++;
        end else begin
          r.stack_overflow = 1'b1;
          push_drops++;
        end
      end
      CMD_POP: begin
        if (save_depth > 0) begin
          save_depth--;
          tur_x  = save_stack[save_depth].x;
          tur_y  = save_stack[save_depth].y;
          tur_hd = save_stack[save_depth].hd;
        end else begin
          empty_pops++;
        end
      end
      CMD_JUMP: begin
        tur_x = b.pos_x;
        tur_y = b.pos_y;
      end
      CMD_SET_HD: tur_hd = b.turn_angle;
      CMD_NARROW: begin
        if (!b.keep_width) begin
          wprod     = 32'(tur_width) * 32'(narrow_cfg);
          tur_width = wprod[31:16];
        end
      end
      default: ;
    endcase
    r.end_x      = tur_x;
    r.end_y      = tur_y;
    r.line_width = tur_width;
    return r;
  endfunction

  function automatic in_beat_t rand_beat(logic [2:0] f);
    in_beat_t b;
    b.func       = f;
    b.pos_x      = 16'($urandom);
    b.pos_y      = 16'($urandom);
    b.turn_angle = 16'($urandom);
    b.keep_width = 1'($urandom);
    return b;
  endfunction

  // table row builders
  function automatic drow_t cmd_row(logic [2:0] f, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] ang, logic keep);
    drow_t r;
    r.kind            = ROW_CMD;
    r.beat.func       = f;
    r.beat.pos_x      = x;
    r.beat.pos_y      = y;
    r.beat.turn_angle = ang;
    r.beat.keep_width = keep;
    r.fixed           = 1'b0;
    r.want            = '0;
    r.reg_idx         = CFG_STEP_LENGTH;
    r.reg_val         = '0;
    return r;
  endfunction

  function automatic drow_t with_want(drow_t r, logic lv, logic [15:0] sx, logic [15:0] sy,
                                      logic [15:0] ex, logic [15:0] ey, logic [15:0] w,
                                      logic ovf);
    r.fixed               = 1'b1;
    r.want.line_valid     = lv;
    r.want.start_x        = sx;
    r.want.start_y        = sy;
    r.want.end_x          = ex;
    r.want.end_y          = ey;
    r.want.line_width     = w;
    r.want.stack_overflow = ovf;
    return r;
  endfunction

  function automatic drow_t cfg_row(cfg_idx_e idx, logic [15:0] val);
    drow_t r;
    r         = cmd_row(CmdUnused, '0, '0, '0, 1'b0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // present one command beat, predict its result once it is taken
  task automatic send_cmd(in_beat_t b, bit fixed = 1'b0, out_beat_t want = '0);
    bit taken;
    out_beat_t pred;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
    pred = turtle_predict(b);
    seg_expect_q.push_back(fixed ? want : pred);
    beats_sent++;
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (seg_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_STEP_LENGTH:   len_cfg = val[9:0];
      CFG_NARROW_FACTOR: narrow_cfg = val;
      CFG_INITIAL_WIDTH: tur_width = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // push then a few moves then pop, the usual shape of a branch
  task automatic play_branch();
    int k;
    logic [2:0] f;
    send_cmd(rand_beat(CMD_PUSH));
    k = $urandom_range(1, 6);
    repeat (k) begin
      case ($urandom_range(7))
        0, 1, 2: f = CMD_FORWARD;
        3:       f = CMD_ROTATE;
        4:       f = CMD_SET_HD;
        5:       f = CMD_NARROW;
        6:       f = CMD_JUMP;
        default: f = CMD_PUSH;
      endcase
      send_cmd(rand_beat(f));
    end
    send_cmd(rand_beat(CMD_POP));
  endtask

  // fill the stack, push past full, then unwind to empty, at times with pops past it
  task automatic play_fill();
    int n;
    while (save_depth < STACK_DEPTH) send_cmd(rand_beat(CMD_PUSH));
    n = $urandom_range(1, 3);
    repeat (n) send_cmd(rand_beat(CMD_PUSH));
    n = save_depth + $urandom_range(0, 2);
    repeat (n) begin
      send_cmd(rand_beat(($urandom_range(3) == 0) ? CMD_FORWARD : CMD_POP));
    end
    while (save_depth > 0) send_cmd(rand_beat(CMD_POP));
  endtask

  // receiver backpressure
  always @(posedge clk_i) begin
    out_stall <= (rcv_idle != 0) && ($urandom_range(99) < rcv_idle);
  end

  task automatic report_bad(string why, out_beat_t want, out_beat_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%s: want lv=%0d s=(%0d,%0d) e=(%0d,%0d) w=%0d ov=%0d",
               why, want.line_valid, want.start_x, want.start_y, want.end_x, want.end_y,
               want.line_width, want.stack_overflow);
      $display("  got lv=%0d s=(%0d,%0d) e=(%0d,%0d) w=%0d ov=%0d",
               got.line_valid, got.start_x, got.start_y, got.end_x, got.end_y,
               got.line_width, got.stack_overflow);
    end
  endtask

  // result check, sampled at the falling edge before the accepting edge
  always @(negedge clk_i) begin
    out_beat_t want;
    if (rst_ni === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (seg_expect_q.size() == 0) begin
        report_bad("unexpected beat", '0, out_data);
      end else begin
        want = seg_expect_q.pop_front();
        beats_checked++;
        if (out_data.line_valid !== want.line_valid ||
            out_data.start_x !== want.start_x || out_data.start_y !== want.start_y ||
            out_data.end_x !== want.end_x || out_data.end_y !== want.end_y ||
            out_data.line_width !== want.line_width ||
            out_data.stack_overflow !== want.stack_overflow) begin
          report_bad("mismatch", want, out_data);
        end
      end
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", seg_expect_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int phase_start, fill_at;
    bit filled, paused;
    logic [9:0]  ph_len;
    logic [15:0] ph_nf, ph_iw;

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    snd_idle  = 37;
    rcv_idle  = 46;
    beats_sent = 0; beats_checked = 0; errors = 0;
    lines_drawn = 0; push_drops = 0; empty_pops = 0;

    build_sine_lut();
    len_cfg    = StepLengthRst;
    narrow_cfg = NarrowFactorRst;
    tur_x = '0; tur_y = '0; tur_hd = '0; tur_width = InitialWidthRst;
    save_depth = 0;

    // directed table: reset values, wraps, empty pop, push/pop back to back, extremes
    dir_rows.push_back(with_want(cmd_row(CMD_FORWARD, 16'h0, 16'h0, 16'h0, 1'b0),
                                 1'b1, 16'd0, 16'd0, 16'd9, 16'd0, 16'd1024, 1'b0));
    dir_rows.push_back(with_want(cmd_row(CMD_POP, 16'h0, 16'h0, 16'h0, 1'b0),
                                 1'b0, 16'd9, 16'd0, 16'd9, 16'd0, 16'd1024, 1'b0));
    dir_rows.push_back(with_want(cmd_row(CMD_JUMP, 16'h7FFF, 16'h8000, 16'h0, 1'b0),
                                 1'b0, 16'd9, 16'd0, 16'h7FFF, 16'h8000, 16'd1024, 1'b0));
    dir_rows.push_back(with_want(cmd_row(CMD_NARROW, 16'h0, 16'h0, 16'h0, 1'b1),
                                 1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd1024,
                                 1'b0));
    dir_rows.push_back(with_want(cmd_row(CMD_NARROW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0),
                                 1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd768,
                                 1'b0));
    dir_rows.push_back(with_want(cmd_row(CMD_PUSH, 16'h0, 16'h0, 16'h0, 1'b0),
                                 1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd768,
                                 1'b0));
    dir_rows.push_back(with_want(cmd_row(CMD_SET_HD, 16'h0, 16'h0, 16'hFFFF, 1'b0),
                                 1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd768,
                                 1'b0));
    dir_rows.push_back(cmd_row(CMD_FORWARD, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cmd_row(CMD_ROTATE, 16'h0, 16'h0, 16'h0001, 1'b0));
    dir_rows.push_back(cmd_row(CMD_POP, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cmd_row(CMD_PUSH, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cmd_row(CMD_POP, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cmd_row(CmdUnused, 16'h1234, 16'hABCD, 16'h5555, 1'b0));
    dir_rows.push_back(with_want(cmd_row(CMD_JUMP, 16'h8000, 16'h7FFF, 16'h0, 1'b0),
                                 1'b0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd768,
                                 1'b0));
    dir_rows.push_back(cfg_row(CFG_STEP_LENGTH, 16'd1023));
    dir_rows.push_back(cmd_row(CMD_SET_HD, 16'h0, 16'h0, 16'h4000, 1'b0));
    dir_rows.push_back(cmd_row(CMD_FORWARD, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cmd_row(CMD_SET_HD, 16'h0, 16'h0, 16'h8000, 1'b0));
    dir_rows.push_back(cmd_row(CMD_FORWARD, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cmd_row(CMD_ROTATE, 16'h0, 16'h0, 16'hC000, 1'b0));
    dir_rows.push_back(cfg_row(CFG_STEP_LENGTH, 16'd0));
    dir_rows.push_back(cmd_row(CMD_FORWARD, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_NARROW_FACTOR, 16'hFFFF));
    dir_rows.push_back(cmd_row(CMD_NARROW, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_NARROW_FACTOR, 16'h0000));
    dir_rows.push_back(cmd_row(CMD_NARROW, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_INITIAL_WIDTH, 16'hFFFF));
    dir_rows.push_back(cmd_row(CMD_NARROW, 16'h0, 16'h0, 16'h0, 1'b1));

    // reset once
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_cmd(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    // random phases, each under its own register setting, with idling mixes shared by pairs of phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin ph_len = StepLengthRst; ph_nf = NarrowFactorRst; ph_iw = InitialWidthRst; end
        1: begin ph_len = 10'd1023; ph_nf = 16'hFFFF; ph_iw = 16'hFFFF; end
        2: begin ph_len = 10'd0; ph_nf = 16'h0000; ph_iw = 16'h0000; end
        4: begin ph_len = 10'd1; ph_nf = 16'h8000; ph_iw = 16'h0100; end
        default: begin
          ph_len = 10'($urandom);
          ph_nf  = 16'($urandom);
          ph_iw  = 16'($urandom);
        end
      endcase
      snd_idle = (ph < 2) ? 37 : (ph < 4) ? 46 : 0;
      rcv_idle = (ph < 2) ? 46 : (ph < 4) ? 37 : 0;
      drain();
      write_reg(CFG_STEP_LENGTH, 16'(ph_len));
      write_reg(CFG_NARROW_FACTOR, ph_nf);
      write_reg(CFG_INITIAL_WIDTH, ph_iw);

      // the fill run goes early so the phase keeps close to its beat budget
      phase_start = beats_sent;
      fill_at     = $urandom_range(0, PHASE_BEATS / 8);
      filled      = 1'b0;
      paused      = 1'b0;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if (!filled && beats_sent - phase_start >= fill_at) begin
          filled = 1'b1;
          play_fill();
        end else if (ph == 1 && !paused && beats_sent - phase_start >= PHASE_BEATS / 2) begin
          // sender holds off until the pipeline is empty
          paused = 1'b1;
          drain();
          send_cmd(rand_beat(CMD_FORWARD));
        end else begin
          case ($urandom_range(99)) inside
            [0:44]:  play_branch();
            [45:89]: send_cmd(rand_beat(3'($urandom_range(0, 6))));
            default: send_cmd(rand_beat(3'($urandom_range(0, 7))));
          endcase
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("%0d commands sent, %0d results checked, %0d segments drawn",
             beats_sent, beats_checked, lines_drawn);
    $display("%0d pushes dropped on a full stack, %0d pops on an empty stack, %0d mismatches",
             push_drops, empty_pops, errors);
    if (errors == 0 && seg_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
